// ----- hdl/rju_pkg.sv -----
`timescale 1ns / 1ps

package rju_pkg;

    // field and datapath widths
    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned QB       = 31;              // quotient magnitude bits
    localparam int unsigned NUM_W    = 112;             // widest dividend
    localparam int unsigned DEN_W    = 96;              // widest divisor
    localparam int unsigned LANES    = 6;
    localparam int unsigned SQ_STAGES  = 32;            // one root bit per stage
    localparam int unsigned DIV_STAGES = QB + 1;        // overflow check + one bit each
    localparam int unsigned LATENCY  = 3 + SQ_STAGES + 2 + DIV_STAGES + 1;

    // configuration port
    localparam int unsigned PADDR_W  = 3;
    localparam logic [0:0]  REG_NEAR_ZERO   = 1'b0;    // paddr[2] of near_zero_limit
    localparam logic [31:0] NEAR_ZERO_RESET = 32'd429497;

    localparam logic [FIELD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] Q_MIN = 32'h8000_0000;

    // divider lanes
    localparam int unsigned L_RANGE_PX   = 0;
    localparam int unsigned L_RANGE_PY   = 1;
    localparam int unsigned L_BEARING_PX = 2;
    localparam int unsigned L_BEARING_PY = 3;
    localparam int unsigned L_RATE_PX    = 4;
    localparam int unsigned L_RATE_PY    = 5;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] vel_x;
        logic signed [FIELD_W-1:0] vel_y;
    } t_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] range_by_px;
        logic signed [FIELD_W-1:0] range_by_py;
        logic signed [FIELD_W-1:0] bearing_by_px;
        logic signed [FIELD_W-1:0] bearing_by_py;
        logic signed [FIELD_W-1:0] rate_by_px;
        logic signed [FIELD_W-1:0] rate_by_py;
        logic signed [FIELD_W-1:0] rate_by_vx;
        logic signed [FIELD_W-1:0] rate_by_vy;
        logic                      too_close;
    } t_result;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } t_div_in;

    typedef struct packed {
        logic [DEN_W:0]   p;      // partial remainder
        logic [QB-1:0]    lo;     // dividend bits not yet brought down
        logic [QB-1:0]    q;
        logic [DEN_W-1:0] den;
        logic             sat;
        logic             neg;
    } t_dst;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [31:0] mpx;
        logic [31:0] mpy;
        logic [63:0] s;
        logic [63:0] cm;
        logic        npx;
        logic        npy;
        logic        c_neg;
        logic        too_close;
    } t_sq;

endpackage

// ----- hdl/rju_divs.sv -----
`timescale 1ns / 1ps

module rju_divs import rju_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_too_close,
    input  t_div_in [LANES-1:0]    i_lane,
    output logic                   o_valid,
    output t_result                o_result
);

    function automatic t_dst div_first(t_div_in x);
        t_dst        b;
        logic [DEN_W:0] hi;
        hi    = (DEN_W+1)'(x.num[NUM_W-1:QB]);
        b.p   = hi;
        b.lo  = x.num[QB-1:0];
        b.q   = '0;
        b.den = x.den;
        b.sat = (hi >= {1'b0, x.den});
        b.neg = x.neg;
        return b;
    endfunction

    function automatic t_dst div_step(t_dst a);
        t_dst        b;
        logic [DEN_W:0] pn;
        b    = a;
        pn   = {a.p[DEN_W-1:0], a.lo[QB-1]};
        b.lo = {a.lo[QB-2:0], 1'b0};
        if (pn >= {1'b0, a.den}) begin
            b.p = pn - {1'b0, a.den};
            b.q = {a.q[QB-2:0], 1'b1};
        end else begin
            b.p = pn;
            b.q = {a.q[QB-2:0], 1'b0};
        end
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] div_final(t_dst a, logic zero);
        logic [FIELD_W-1:0] m;
        m = {1'b0, a.q};
        if (zero) begin
            return '0;
        end else if (a.sat) begin
            return a.neg ? Q_MIN : Q_MAX;
        end else begin
            return a.neg ? (~m + 1'b1) : m;
        end
    endfunction

    t_dst [LANES-1:0] r_st  [DIV_STAGES];
    logic             r_vld [DIV_STAGES];
    logic             r_tc  [DIV_STAGES];
    logic             r_valid_o;
    t_result          r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tc[0] <= i_too_close;
        for (int l = 0; l < LANES; l++) begin
            r_st[0][l] <= div_first(i_lane[l]);
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tc[j] <= r_tc[j-1];
            for (int l = 0; l < LANES; l++) begin
                r_st[j][l] <= div_step(r_st[j-1][l]);
            end
        end
    end

    // sign, saturation and near-zero blanking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_o <= 1'b0;
        end else begin
            r_valid_o <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.range_by_px   <= div_final(r_st[DIV_STAGES-1][L_RANGE_PX],   r_tc[DIV_STAGES-1]);
        r_res.range_by_py   <= div_final(r_st[DIV_STAGES-1][L_RANGE_PY],   r_tc[DIV_STAGES-1]);
        r_res.bearing_by_px <= div_final(r_st[DIV_STAGES-1][L_BEARING_PX], r_tc[DIV_STAGES-1]);
        r_res.bearing_by_py <= div_final(r_st[DIV_STAGES-1][L_BEARING_PY], r_tc[DIV_STAGES-1]);
        r_res.rate_by_px    <= div_final(r_st[DIV_STAGES-1][L_RATE_PX],    r_tc[DIV_STAGES-1]);
        r_res.rate_by_py    <= div_final(r_st[DIV_STAGES-1][L_RATE_PY],    r_tc[DIV_STAGES-1]);
        r_res.rate_by_vx    <= div_final(r_st[DIV_STAGES-1][L_RANGE_PX],   r_tc[DIV_STAGES-1]);
        r_res.rate_by_vy    <= div_final(r_st[DIV_STAGES-1][L_RANGE_PY],   r_tc[DIV_STAGES-1]);
        r_res.too_close     <= r_tc[DIV_STAGES-1];
    end

    assign o_valid  = r_valid_o;
    assign o_result = r_res;

endmodule

// ----- hdl/radar_jacobian_unit.sv -----
`timescale 1ns / 1ps

// Radar measurement Jacobian for an extended Kalman filter.
//
// Command channel: start with i_item (px, py, vx, vy, signed Q16.16). A
// transaction is taken at each rising edge with start high and busy low;
// busy is always low, so one state vector can be issued every cycle.
// Result channel: o_valid is high for exactly one cycle with o_result, the
// eight nonzero Jacobian entries (Q16.16, truncated, saturated) and the
// too_close flag. The receiver cannot stall; results are never held.
// The datapath is the 32-stage root pipeline (one root bit per stage)
// and the 32-stage restoring dividers (overflow check then one quotient bit
// per stage), plus three front-end, two multiply and one output stage.
// Throughput: one transaction per cycle, sustained.
// Config: APB-style, near_zero_limit at byte address 0, writable any time
// the pipeline is empty. Reset (synchronous, active low) flushes all valid
// bits and sets near_zero_limit to about 0.0001 in Q32.32.

module radar_jacobian_unit import rju_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_item              i_item,
    output logic               o_valid,
    output t_result            o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // ---------------- configuration ----------------
    logic [31:0] r_limit;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NEAR_ZERO) ? r_limit : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= NEAR_ZERO_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_NEAR_ZERO) begin
            r_limit <= pwdata;
        end
    end

    // ---------------- stage 1: sign / magnitude ----------------
    logic        r_v1;
    logic [31:0] r_mpx, r_mpy, r_mvx, r_mvy;
    logic        r_npx, r_npy, r_nvx, r_nvy;

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? (~v + 1'b1) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mpx <= mag(i_item.pos_x);
        r_mpy <= mag(i_item.pos_y);
        r_mvx <= mag(i_item.vel_x);
        r_mvy <= mag(i_item.vel_y);
        r_npx <= i_item.pos_x[31];
        r_npy <= i_item.pos_y[31];
        r_nvx <= i_item.vel_x[31];
        r_nvy <= i_item.vel_y[31];
    end

    // ---------------- stage 2: squares and cross products ----------------
    logic        r_v2;
    logic [63:0] r_px2, r_py2, r_ta, r_tb;
    logic [31:0] r_mpx2, r_mpy2;
    logic        r_npx2, r_npy2, r_nvx2, r_nvy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px2  <= 64'(r_mpx) * 64'(r_mpx);
        r_py2  <= 64'(r_mpy) * 64'(r_mpy);
        r_ta   <= 64'(r_mvx) * 64'(r_mpy);     // |vx*py|
        r_tb   <= 64'(r_mvy) * 64'(r_mpx);     // |vy*px|
        r_mpx2 <= r_mpx;
        r_mpy2 <= r_mpy;
        r_npx2 <= r_npx;
        r_npy2 <= r_npy;
        r_nvx2 <= r_nvx;
        r_nvy2 <= r_nvy;
    end

    // ---------------- stage 3: s, cross term, near-zero test ----------------
    logic  r_v3;
    t_sq   r_s3;
    logic  ta_neg, tb_neg;
    logic [63:0] s_sum;

    assign s_sum  = r_px2 + r_py2;
    // vx*py carries +, vy*px carries - in the cross term
    assign ta_neg = (r_nvx2 ^ r_npy2) && (r_ta != 64'd0);
    assign tb_neg = !(r_nvy2 ^ r_npx2) && (r_tb != 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3.rem       <= '0;
        r_s3.root      <= '0;
        r_s3.mpx       <= r_mpx2;
        r_s3.mpy       <= r_mpy2;
        r_s3.s         <= s_sum;
        r_s3.npx       <= r_npx2;
        r_s3.npy       <= r_npy2;
        r_s3.too_close <= (s_sum <= {32'd0, r_limit});
        if (ta_neg == tb_neg) begin
            r_s3.cm    <= r_ta + r_tb;
            r_s3.c_neg <= ta_neg;
        end else if (r_ta >= r_tb) begin
            r_s3.cm    <= r_ta - r_tb;
            r_s3.c_neg <= ta_neg;
        end else begin
            r_s3.cm    <= r_tb - r_ta;
            r_s3.c_neg <= tb_neg;
        end
    end

    // ---------------- integer square root, one bit per stage ----------------
    t_sq  r_sq  [SQ_STAGES];
    logic r_vsq [SQ_STAGES];

    for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
        localparam int unsigned K = SQ_STAGES - 1 - i;  // digit pair consumed here
        t_sq         prev, nxt;
        logic        prev_v;
        logic [35:0] rem_sh, trial;

        if (i == 0) begin : g_first
            assign prev   = r_s3;
            assign prev_v = r_v3;
        end else begin : g_next
            assign prev   = r_sq[i-1];
            assign prev_v = r_vsq[i-1];
        end

        assign rem_sh = {prev.rem, prev.s[2*K+1 -: 2]};
        assign trial  = {2'b00, prev.root, 2'b01};

        always_comb begin
            nxt = prev;
            if (rem_sh >= trial) begin
                nxt.rem  = 34'(rem_sh - trial);
                nxt.root = {prev.root[30:0], 1'b1};
            end else begin
                nxt.rem  = 34'(rem_sh);
                nxt.root = {prev.root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vsq[i] <= 1'b0;
            end else begin
                r_vsq[i] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq[i] <= nxt;
        end
    end

    // ---------------- M1: 32x32 partial products ----------------
    t_sq         sq_o;
    logic        r_vm1;
    logic [63:0] r_srl, r_srh, r_ylo, r_yhi, r_xlo, r_xhi;
    t_sq         r_m1;

    assign sq_o = r_sq[SQ_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
        end else begin
            r_vm1 <= r_vsq[SQ_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_srl <= 64'(sq_o.s[31:0])   * 64'(sq_o.root);
        r_srh <= 64'(sq_o.s[63:32])  * 64'(sq_o.root);
        r_ylo <= 64'(sq_o.mpy)       * 64'(sq_o.cm[31:0]);
        r_yhi <= 64'(sq_o.mpy)       * 64'(sq_o.cm[63:32]);
        r_xlo <= 64'(sq_o.mpx)       * 64'(sq_o.cm[31:0]);
        r_xhi <= 64'(sq_o.mpx)       * 64'(sq_o.cm[63:32]);
        r_m1  <= sq_o;
    end

    // ---------------- M2: assemble dividends and divisors ----------------
    logic               r_vm2;
    logic               r_tc2;
    t_div_in [LANES-1:0] r_lane;
    logic [DEN_W-1:0]   den_sr, num_y, num_x;

    assign den_sr = {32'd0, r_srl} + {r_srh, 32'd0};
    assign num_y  = {32'd0, r_ylo} + {r_yhi, 32'd0};
    assign num_x  = {32'd0, r_xlo} + {r_xhi, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm2 <= 1'b0;
        end else begin
            r_vm2 <= r_vm1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tc2 <= r_m1.too_close;
        // px / r, py / r
        r_lane[L_RANGE_PX]   <= '{num: {64'd0, r_m1.mpx, 16'd0},
                                  den: {64'd0, r_m1.root}, neg: r_m1.npx};
        r_lane[L_RANGE_PY]   <= '{num: {64'd0, r_m1.mpy, 16'd0},
                                  den: {64'd0, r_m1.root}, neg: r_m1.npy};
        // -py / s, px / s
        r_lane[L_BEARING_PX] <= '{num: {48'd0, r_m1.mpy, 32'd0},
                                  den: {32'd0, r_m1.s}, neg: !r_m1.npy};
        r_lane[L_BEARING_PY] <= '{num: {48'd0, r_m1.mpx, 32'd0},
                                  den: {32'd0, r_m1.s}, neg: r_m1.npx};
        // py*C / (s*r), -px*C / (s*r)
        r_lane[L_RATE_PX]    <= '{num: {num_y, 16'd0}, den: den_sr,
                                  neg: r_m1.npy ^ r_m1.c_neg};
        r_lane[L_RATE_PY]    <= '{num: {num_x, 16'd0}, den: den_sr,
                                  neg: !(r_m1.npx ^ r_m1.c_neg)};
    end

    // ---------------- dividers and output register ----------------
    rju_divs u_divs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_vm2),
        .i_too_close (r_tc2),
        .i_lane      (r_lane),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    // near-zero results carry no entries
    a_too_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.too_close) |->
            (o_result.range_by_px == 0 && o_result.range_by_py == 0 &&
             o_result.bearing_by_px == 0 && o_result.bearing_by_py == 0 &&
             o_result.rate_by_px == 0 && o_result.rate_by_py == 0 &&
             o_result.rate_by_vx == 0 && o_result.rate_by_vy == 0))
        else $error("too_close result with nonzero entries");

    // velocity partials mirror the range row
    a_rate_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.rate_by_vx == o_result.range_by_px &&
                     o_result.rate_by_vy == o_result.range_by_py))
        else $error("range-rate velocity partials differ from range row");

    // every transaction comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("result strobe missing at fixed latency");
`endif

endmodule
